// ----- rtl/rgbycc_pkg.sv -----
package rgbycc_pkg;

  localparam int CfgDimW = 13;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 13;
  localparam int SumW = 26;

  localparam logic [CfgDimW-1:0] WidthReset = 13'd640;
  localparam logic [CfgDimW-1:0] HeightReset = 13'd480;

  localparam logic [15:0] CoefYR = 16'd19595;
  localparam logic [15:0] CoefYG = 16'd38470;
  localparam logic [15:0] CoefYB = 16'd7471;
  localparam logic [15:0] CoefCbR = 16'd11056;
  localparam logic [15:0] CoefCbG = 16'd21712;
  localparam logic [15:0] CoefHalf = 16'd32768;
  localparam logic [15:0] CoefCrG = 16'd27440;
  localparam logic [15:0] CoefCrB = 16'd5328;
  localparam logic [SumW-1:0] RoundTerm = 26'd32768;
  localparam logic [SumW-1:0] ChromaOffset = 26'd8388608;
  localparam logic [9:0] PixMax = 10'd255;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_CHROMA_FORMAT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FMT_444 = 2'd0,
    FMT_422 = 2'd1,
    FMT_420 = 2'd2
  } chroma_fmt_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] blue_diff;
    logic [7:0] red_diff;
    logic       chroma_kept;
    logic       row_end;
    logic       frame_end;
  } pix_out_t;

endpackage

// ----- rtl/rgb_to_ycbcr_subsample_core.sv -----
// RGB to full-range BT.601 YCbCr converter with chroma subsampling flags. One pixel
// transfer per clock is sustained in raster order while out_stall stays low; each result
// passes through an input register holding the pixel and its frame-position flags,
// then the result register fed by the fixed-point multiply-add and clamp. The column
// and row counters advance on every input transfer and restart at the configured frame
// size, where 0 acts as 1 and sizes above MAX_DIM act as MAX_DIM. Write the configuration
// registers only while the pipeline is empty; cfg_ready is always high.
module rgb_to_ycbcr_subsample_core
  import rgbycc_pkg::*;
#(
  parameter int MAX_DIM = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pix_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pix_out_t            out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int CntW = $clog2(MAX_DIM);
  localparam int CmpW = (CntW > CfgDimW) ? CntW + 1 : CfgDimW + 1;

  logic [CfgDimW-1:0] frame_width_r;
  logic [CfgDimW-1:0] frame_height_r;
  logic [1:0]         chroma_format_r;

  logic [CntW-1:0] col_r, col_nxt;
  logic [CntW-1:0] row_r, row_nxt;

  logic       s1_valid_r;
  pix_in_t    s1_pix_r;
  logic       s1_keep_r, s1_row_end_r, s1_frame_end_r;
  logic       out_valid_r;
  pix_out_t   out_data_r;

  logic adv1, adv2, in_xfer;
  logic [CmpW-1:0] w_lim, h_lim, last_col, last_row;
  logic row_end, frame_end, keep;
  logic [SumW-1:0] y_sum, cb_sum, cr_sum;
  logic [9:0] y_q, cb_q, cr_q;

  function automatic logic [CmpW-1:0] limit_dim(input logic [CfgDimW-1:0] v);
    logic [CmpW-1:0] res;
    res = CmpW'(v);
    if (v == '0) begin
      res = CmpW'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      res = CmpW'(MAX_DIM);
    end
    return res;
  endfunction

  function automatic logic [7:0] clamp255(input logic [9:0] v);
    return (v > PixMax) ? 8'hFF : v[7:0];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= WidthReset;
      frame_height_r  <= HeightReset;
      chroma_format_r <= FMT_444;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:   frame_width_r <= cfg_data;
        REG_FRAME_HEIGHT:  frame_height_r <= cfg_data;
        REG_CHROMA_FORMAT: chroma_format_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign adv2     = !out_valid_r || !out_stall;
  assign adv1     = !s1_valid_r || adv2;
  assign in_stall = !adv1;
  assign in_xfer  = in_valid && adv1;

  always_comb begin
    w_lim     = limit_dim(frame_width_r);
    h_lim     = limit_dim(frame_height_r);
    last_col  = w_lim - CmpW'(1);
    last_row  = h_lim - CmpW'(1);
    row_end   = CmpW'(col_r) >= last_col;
    frame_end = row_end && (CmpW'(row_r) >= last_row);
    unique case (chroma_format_r)
      FMT_444: keep = 1'b1;
      FMT_422: keep = !col_r[0];
      FMT_420: keep = !col_r[0] && !row_r[0];
      default: keep = 1'b0;
    endcase
    col_nxt = row_end ? '0 : col_r + CntW'(1);
    row_nxt = row_r;
    if (row_end) begin
      row_nxt = frame_end ? '0 : row_r + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else if (adv1) begin
      s1_valid_r <= in_valid;
      if (in_valid) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pix_r       <= in_data;
      s1_keep_r      <= keep;
      s1_row_end_r   <= row_end;
      s1_frame_end_r <= frame_end;
    end
  end

  always_comb begin
    y_sum  = SumW'(CoefYR) * SumW'(s1_pix_r.red)
           + SumW'(CoefYG) * SumW'(s1_pix_r.green)
           + SumW'(CoefYB) * SumW'(s1_pix_r.blue)
           + RoundTerm;
    cb_sum = SumW'(CoefHalf) * SumW'(s1_pix_r.blue) + RoundTerm + ChromaOffset
           - SumW'(CoefCbR) * SumW'(s1_pix_r.red)
           - SumW'(CoefCbG) * SumW'(s1_pix_r.green);
    cr_sum = SumW'(CoefHalf) * SumW'(s1_pix_r.red) + RoundTerm + ChromaOffset
           - SumW'(CoefCrG) * SumW'(s1_pix_r.green)
           - SumW'(CoefCrB) * SumW'(s1_pix_r.blue);
    y_q  = y_sum[SumW-1:16];
    cb_q = cb_sum[SumW-1:16];
    cr_q = cr_sum[SumW-1:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv2) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid_r) begin
      out_data_r.luma        <= clamp255(y_q);
      out_data_r.blue_diff   <= clamp255(cb_q);
      out_data_r.red_diff    <= clamp255(cr_q);
      out_data_r.chroma_kept <= s1_keep_r;
      out_data_r.row_end     <= s1_row_end_r;
      out_data_r.frame_end   <= s1_frame_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbycc_pkg::*;

  localparam int MaxDim = 4096;
  localparam int QuietLimit = 2000;
  localparam int ReportCap = 40;

  localparam logic [CfgDimW-1:0] DefWidth = 13'd640;
  localparam logic [CfgDimW-1:0] DefHeight = 13'd480;
  localparam logic [1:0] FmtReserved = 2'd3;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  localparam int unsigned KYr = 19595;
  localparam int unsigned KYg = 38470;
  localparam int unsigned KYb = 7471;
  localparam int unsigned KCbR = 11056;
  localparam int unsigned KCbG = 21712;
  localparam int unsigned KHalf = 32768;
  localparam int unsigned KCrG = 27440;
  localparam int unsigned KCrB = 5328;
  localparam int unsigned KRound = 32768;
  localparam int unsigned KChromaBias = 128 * 65536;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  pix_in_t             in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  pix_out_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  rgb_to_ycbcr_subsample_core #(.MAX_DIM(MaxDim)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [CfgDimW-1:0] frame_w = DefWidth;
  logic [CfgDimW-1:0] frame_h = DefHeight;
  logic [1:0]         chroma_fmt = FMT_444;
  int unsigned        col_count = 0;
  int unsigned        row_count = 0;

  pix_out_t expected_pixels[$];

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int pixels_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned dim_limit(logic [CfgDimW-1:0] v);
    if (v == 0) return 1;
    if (v > MaxDim) return MaxDim;
    return 32'(v);
  endfunction

  function automatic logic [7:0] clamp_byte(int unsigned v);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic pix_out_t predict_pixel(pix_in_t px);
    pix_out_t res;
    int unsigned r, g, b, w, h, y, cb, cr;
    logic even_col, even_row;
    r = 32'(px.red);
    g = 32'(px.green);
    b = 32'(px.blue);
    w = dim_limit(frame_w);
    h = dim_limit(frame_h);
    y = (KYr * r + KYg * g + KYb * b + KRound) >> 16;
    cb = (KHalf * b + KRound + KChromaBias - KCbR * r - KCbG * g) >> 16;
    cr = (KHalf * r + KRound + KChromaBias - KCrG * g - KCrB * b) >> 16;
    res.luma = clamp_byte(y);
    res.blue_diff = clamp_byte(cb);
    res.red_diff = clamp_byte(cr);
    even_col = (col_count[0] == 1'b0);
    even_row = (row_count[0] == 1'b0);
    case (chroma_fmt)
      FMT_444: res.chroma_kept = 1'b1;
      FMT_422: res.chroma_kept = even_col;
      FMT_420: res.chroma_kept = even_col && even_row;
      default: res.chroma_kept = 1'b0;
    endcase
    res.row_end = (col_count >= w - 1);
    res.frame_end = res.row_end && (row_count >= h - 1);
    return res;
  endfunction

  function automatic pix_in_t rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pix_in_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    return px;
  endfunction

  function automatic logic [7:0] random_level();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pix_in_t random_pixel();
    return rgb(random_level(), random_level(), random_level());
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatches++;
    if (mismatches <= ReportCap)
      $display("MISMATCH at result %0d, %s: got %0h want %0h", results_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    pix_out_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          REG_FRAME_WIDTH: frame_w = cfg_data;
          REG_FRAME_HEIGHT: frame_h = cfg_data;
          REG_CHROMA_FORMAT: chroma_fmt = cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want = predict_pixel(in_data);
        expected_pixels.push_back(want);
        if (want.row_end) begin
          col_count = 0;
          row_count = want.frame_end ? 0 : row_count + 1;
        end else begin
          col_count = col_count + 1;
        end
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_pixels.size() == 0) begin
          report_mismatch("result with nothing pending", 16'(out_data), 16'h0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.luma !== want.luma)
            report_mismatch("luma", 16'(out_data.luma), 16'(want.luma));
          if (out_data.blue_diff !== want.blue_diff)
            report_mismatch("blue_diff", 16'(out_data.blue_diff), 16'(want.blue_diff));
          if (out_data.red_diff !== want.red_diff)
            report_mismatch("red_diff", 16'(out_data.red_diff), 16'(want.red_diff));
          if (out_data.chroma_kept !== want.chroma_kept)
            report_mismatch("chroma_kept", 16'(out_data.chroma_kept),
                            16'(want.chroma_kept));
          if (out_data.row_end !== want.row_end)
            report_mismatch("row_end", 16'(out_data.row_end), 16'(want.row_end));
          if (out_data.frame_end !== want.frame_end)
            report_mismatch("frame_end", 16'(out_data.frame_end), 16'(want.frame_end));
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < out_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    do @(posedge clk); while (quiet_cycles < QuietLimit);
    $display("Watchdog: no transfer for %0d cycles", QuietLimit);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_pixel(pix_in_t px);
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_data <= px;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
  endtask

  // drop valid and wait until the pipeline has drained
  task automatic settle();
    in_valid <= 1'b0;
    repeat (3) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_color_extremes();
    in_idle_pct = 0;
    out_stall_pct = 0;
    send_pixel(rgb(8'h00, 8'h00, 8'h00));
    send_pixel(rgb(8'hFF, 8'hFF, 8'hFF));
    send_pixel(rgb(8'hFF, 8'h00, 8'h00));
    send_pixel(rgb(8'h00, 8'hFF, 8'h00));
    send_pixel(rgb(8'h00, 8'h00, 8'hFF));
    send_pixel(rgb(8'hFF, 8'hFF, 8'h00));
    settle();
  endtask

  task automatic test_chroma_formats();
    write_reg(REG_FRAME_WIDTH, 13'd2);
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    write_reg(REG_CHROMA_FORMAT, {11'($urandom), FMT_420});
    repeat (4) send_pixel(random_pixel());
    settle();
    write_reg(REG_CHROMA_FORMAT, {11'($urandom), FMT_422});
    repeat (4) send_pixel(random_pixel());
    settle();
    write_reg(REG_CHROMA_FORMAT, {11'($urandom), FmtReserved});
    repeat (2) send_pixel(random_pixel());
    settle();
  endtask

  task automatic test_size_limits();
    write_reg(REG_FRAME_WIDTH, 13'd0);
    write_reg(REG_FRAME_HEIGHT, 13'd0);
    write_reg(REG_CHROMA_FORMAT, {11'($urandom), FMT_444});
    repeat (2) send_pixel(random_pixel());
    settle();
    write_reg(RegUnused, 13'($urandom));
    send_pixel(random_pixel());
    settle();
  endtask

  task automatic test_resize_midframe();
    write_reg(REG_FRAME_WIDTH, 13'd6);
    write_reg(REG_FRAME_HEIGHT, 13'd4);
    repeat (4) send_pixel(random_pixel());
    settle();
    write_reg(REG_FRAME_WIDTH, 13'd3);
    repeat (4) send_pixel(random_pixel());
    settle();
    write_reg(REG_FRAME_HEIGHT, 13'd2);
    repeat (3) send_pixel(random_pixel());
    settle();
  endtask

  task automatic test_max_frames();
    in_idle_pct = 13;
    out_stall_pct = 13;
    write_reg(REG_FRAME_WIDTH, 13'h1FFF);
    write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
    repeat (24) send_pixel(random_pixel());
    settle();
    write_reg(REG_FRAME_WIDTH, 13'd1);
    write_reg(REG_FRAME_HEIGHT, 13'd4097);
    repeat (24) send_pixel(random_pixel());
    settle();
  endtask

  task automatic test_random_frames(int idle_pct, int stall_pct, int n_items);
    int sent;
    int burst;
    int unsigned w, h;
    logic [CfgDimW-1:0] wv, hv;
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      settle();
      wv = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(12));
      hv = ($urandom_range(9) == 0) ? 13'($urandom) : 13'($urandom_range(8));
      if ($urandom_range(3) != 0) write_reg(REG_FRAME_WIDTH, wv);
      if ($urandom_range(3) != 0) write_reg(REG_FRAME_HEIGHT, hv);
      if ($urandom_range(3) != 0)
        write_reg(REG_CHROMA_FORMAT, {11'($urandom), 2'($urandom_range(3))});
      if ($urandom_range(15) == 0) write_reg(RegUnused, 13'($urandom));
      w = dim_limit(frame_w);
      h = dim_limit(frame_h);
      if ($urandom_range(3) != 0 && w * h <= 60)
        burst = w * h * $urandom_range(1, 2);
      else
        burst = $urandom_range(1, 40);
      repeat (burst) send_pixel(random_pixel());
      sent += burst;
    end
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_color_extremes();
    test_chroma_formats();
    test_size_limits();
    test_resize_midframe();
    test_max_frames();
    test_random_frames(0, 0, 255);
    test_random_frames(80, 0, 255);
    test_random_frames(0, 80, 255);
    test_random_frames(13, 13, 255);
    settle();
    if (expected_pixels.size() != 0)
      report_mismatch("results never returned", 16'(expected_pixels.size()), 16'h0);
    $display("Run covered %0d pixels, %0d results and %0d register writes,", pixels_sent,
             results_seen, cfg_writes);
    $display("across extreme colors, all chroma formats, size limits and four idle/stall mixes");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/rgbycc_pkg.sv
rtl/rgb_to_ycbcr_subsample_core.sv
tb/sv/tb_top.sv
